>>> hw/rtl/homopolymer_run_filter_unit_assert.svh
// Assertion macros for the homopolymer run filter.
// Included by the top level, which carries concurrent checks; no other dependencies.
`ifndef HOMOPOLYMER_RUN_FILTER_UNIT_ASSERT_SVH
`define HOMOPOLYMER_RUN_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define HRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrf assertion failed");

// Next-cycle implication, disabled while in reset.
`define HRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrf assertion failed");

`endif

>>> hw/rtl/hrf_pkg.sv
// Shared constants for the homopolymer run filter.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package hrf_pkg;

    localparam int unsigned BASE_W    = 8;
    localparam int unsigned MAX_RUN_W = 16;

    localparam logic [BASE_W-1:0]    UNCALLED_BASE = 8'd78;   // 'N'
    localparam logic [MAX_RUN_W-1:0] MAX_RUN_RESET = 16'd65534;

endpackage

`default_nettype wire

>>> hw/rtl/hrf_if.sv
// Valid/ready channel interfaces of the homopolymer run filter:
// base stream, result stream and max_run write channel. Depends on hrf_pkg.
`default_nettype none

interface hrf_base_if
    import hrf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base;
    logic              last_base;

    modport source (output valid, output base, output last_base, input ready);
    modport sink   (input valid, input base, input last_base, output ready);
endinterface

interface hrf_result_if;
    logic valid;
    logic ready;
    logic read_ok;

    modport source (output valid, output read_ok, input ready);
    modport sink   (input valid, input read_ok, output ready);
endinterface

interface hrf_cfg_if
    import hrf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MAX_RUN_W-1:0] max_run;

    modport source (output valid, output max_run, input ready);
    modport sink   (input valid, input max_run, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/homopolymer_run_filter_unit.sv
// Homopolymer run filter top level: input stage, run counters, result register.
// Depends on hrf_pkg, the interfaces in hrf_if.sv and the assertion macro header.
`default_nettype none
`include "homopolymer_run_filter_unit_assert.svh"

// Takes one base per cycle and, on the beat flagged last_base, returns one
// read_ok beat: 1 when no homopolymer run in the read (an 'N' counted both as
// extension of the base before it and of the base after it) went above
// max_run. Bases are registered in the input stage on accept and processed
// from there; the result register is loaded when the last base leaves the input
// stage. The loop through the run counters sets the rate at one base per clock
// while no result is pending; only a result that is not taken stalls the base
// stream. Counters saturate at COUNT_BITS ones. max_run resets to 65534 and is
// written through cfg, which is always ready.
module homopolymer_run_filter_unit
    import hrf_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire            clk,
    input  wire            rst_n,
    hrf_base_if.sink       bases,
    hrf_result_if.source   results,
    hrf_cfg_if.sink        cfg
);

    localparam int unsigned CMP_W = (COUNT_BITS > MAX_RUN_W) ? COUNT_BITS : MAX_RUN_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

    logic [MAX_RUN_W-1:0]  max_run_reg;

    logic                  s1_valid_reg;
    logic [BASE_W-1:0]     s1_base_reg;
    logic                  s1_last_reg;

    logic [COUNT_BITS-1:0] run_back_reg, run_back_next;
    logic [COUNT_BITS-1:0] run_fwd_reg, run_fwd_next;
    logic [COUNT_BITS-1:0] longest_reg, longest_next;
    logic [BASE_W-1:0]     prior_base_reg, prior_called_reg;
    logic                  failed_reg, failed_next;

    logic                  out_valid_reg;
    logic                  read_ok_reg;

    logic                  proc_fire;
    logic                  base_fire;
    logic                  extend;
    logic [COUNT_BITS-1:0] back_inc, fwd_inc, longest_tmp;

    // A last beat can only move into the result register when it is free or is being read in the same cycle.
    assign proc_fire = s1_valid_reg && (!s1_last_reg || !out_valid_reg || results.ready);
    assign bases.ready = !s1_valid_reg || proc_fire;
    assign base_fire = bases.valid && bases.ready;

    assign cfg.ready = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.read_ok = read_ok_reg;

    always_comb
    begin
        back_inc = (run_back_reg == COUNT_MAX) ? run_back_reg : run_back_reg + COUNT_ONE;
        fwd_inc  = (run_fwd_reg == COUNT_MAX) ? run_fwd_reg : run_fwd_reg + COUNT_ONE;
        extend   = (s1_base_reg == UNCALLED_BASE) || (s1_base_reg == prior_called_reg);

        if (extend)
        begin
            run_back_next = back_inc;
            run_fwd_next  = fwd_inc;
        end
        else if (prior_base_reg == UNCALLED_BASE)
        begin
            // N run ahead of a new base: it still counts toward that base
            run_back_next = COUNT_ONE;
            run_fwd_next  = fwd_inc;
        end
        else
        begin
            run_back_next = COUNT_ONE;
            run_fwd_next  = '0;
        end

        longest_tmp  = (run_back_next > longest_reg) ? run_back_next : longest_reg;
        longest_next = (run_fwd_next > longest_tmp) ? run_fwd_next : longest_tmp;
        failed_next  = failed_reg ||
                       (CMP_W'(longest_next) > CMP_W'(max_run_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_run_reg <= MAX_RUN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_run_reg <= cfg.max_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (base_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (proc_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (base_fire)
        begin
            s1_base_reg <= bases.base;
            s1_last_reg <= bases.last_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_back_reg     <= '0;
            run_fwd_reg      <= '0;
            longest_reg      <= '0;
            prior_base_reg   <= UNCALLED_BASE;
            prior_called_reg <= UNCALLED_BASE;
            failed_reg       <= 1'b0;
        end
        else if (proc_fire)
        begin
            if (s1_last_reg)
            begin
                run_back_reg     <= '0;
                run_fwd_reg      <= '0;
                longest_reg      <= '0;
                prior_base_reg   <= UNCALLED_BASE;
                prior_called_reg <= UNCALLED_BASE;
                failed_reg       <= 1'b0;
            end
            else
            begin
                run_back_reg   <= run_back_next;
                run_fwd_reg    <= run_fwd_next;
                longest_reg    <= longest_next;
                prior_base_reg <= s1_base_reg;
                if (s1_base_reg != UNCALLED_BASE)
                begin
                    prior_called_reg <= s1_base_reg;
                end
                failed_reg     <= failed_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && s1_last_reg)
        begin
            read_ok_reg <= !failed_next;
        end
    end

    `HRF_ASSERT_NEXT(a_run_back_nonzero, clk, rst_n, proc_fire && !s1_last_reg,
        run_back_reg != '0)
    `HRF_ASSERT_NOW(a_longest_covers, clk, rst_n, 1'b1,
        (longest_reg >= run_back_reg) && (longest_reg >= run_fwd_reg))
    `HRF_ASSERT_NEXT(a_fail_sticky, clk, rst_n, failed_reg && !(proc_fire && s1_last_reg),
        failed_reg)
    `HRF_ASSERT_NOW(a_no_result_overrun, clk, rst_n,
        proc_fire && s1_last_reg && out_valid_reg, results.ready)

endmodule

`default_nettype wire
